/* src/assert_macros.svh */
// Clocked assertion helpers; the using module provides i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check a condition at the edge that follows a trigger.
`define ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

/* src/sgwp_pkg.sv */
`timescale 1ns / 1ps
package sgwp_pkg;

    localparam int VERTEX_W = 4;
    localparam int ROW_W    = 16;
    localparam int COUNT_W  = 5;
    localparam int ROW_CAP  = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd11;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic                found;
        logic                last;
    } t_result;

endpackage

/* src/sgwp_pick.sv */
`timescale 1ns / 1ps
module sgwp_pick #(
    parameter int NV = 16,
    parameter int AW = 4
) (
    input  logic [NV-1:0]                i_row,
    input  logic [NV-1:0]                i_visited,
    input  logic [sgwp_pkg::COUNT_W-1:0] i_lim,
    output logic                         o_any,
    output logic [AW-1:0]                o_idx
);

    logic [NV-1:0] cand;

    // Candidates: edges to unvisited vertices below the active count.
    always_comb begin
        for (int i = 0; i < NV; i++) begin
            cand[i] = i_row[i] & ~i_visited[i] & (sgwp_pkg::COUNT_W'(i) < i_lim);
        end
    end

    // Lowest candidate wins.
    always_comb begin
        o_idx = '0;
        for (int i = NV - 1; i >= 0; i--) begin
            if (cand[i]) begin
                o_idx = AW'(i);
            end
        end
    end

    assign o_any = |cand;

endmodule

/* src/sgwp_obuf.sv */
`timescale 1ns / 1ps
module sgwp_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sgwp_pkg::t_result i_data,
    input  logic              i_stall,
    output logic              o_valid,
    output sgwp_pkg::t_result o_data,
    output logic              o_free
);

    logic              r_valid;
    sgwp_pkg::t_result r_data;

    // Free when empty or the held result leaves at this edge.
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* src/stack_graph_walk_path.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Depth-first path search over a small adjacency-matrix graph.
// Input channel (i_in_valid / o_in_stall): each request is either a row load
// (i_action = 0) that writes one adjacency row, or a path query
// (i_action = 1) from i_start_vertex to i_end_vertex. A row load gives no
// result. A query holds o_in_stall high until its last result is in the
// output register, so one query is in flight at a time. A query pushes the
// start, pops vertices, reading each one's row and pushing each unvisited
// neighbour, finds the stack empty, checks the end, walks the parent memory
// from the end to the start while stacking the path, and pops the stack
// memory into the output register. An out-of-range query skips the search.
// Output channel (o_out_valid / i_out_stall): the path, start first, with
// o_last on its final vertex; an unreachable or out-of-range end gives one
// result with o_found low. A stalled result holds in the output register and
// holds the emission until it leaves. Configuration: i_cfg_wr_en writes
// vertex_count; write only while idle. Reset (synchronous, active low) empties
// the stack and output register, clears visited marks and row valid bits.
module stack_graph_walk_path #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [sgwp_pkg::COUNT_W-1:0]  i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [sgwp_pkg::VERTEX_W-1:0] i_row_index,
    input  logic [sgwp_pkg::ROW_W-1:0]    i_row_bits,
    input  logic [sgwp_pkg::VERTEX_W-1:0] i_start_vertex,
    input  logic [sgwp_pkg::VERTEX_W-1:0] i_end_vertex,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sgwp_pkg::VERTEX_W-1:0] o_vertex,
    output logic                          o_found,
    output logic                          o_last
);

    localparam int NV  = (MAX_VERTICES < sgwp_pkg::ROW_CAP) ? MAX_VERTICES
                                                            : sgwp_pkg::ROW_CAP;
    localparam int AW  = $clog2(NV);
    localparam int SPW = $clog2(NV + 1);
    localparam int CW  = sgwp_pkg::COUNT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_POP    = 4'd1;
    localparam logic [3:0] S_ROW    = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_WALK   = 4'd5;
    localparam logic [3:0] S_WALK_W = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;
    localparam logic [3:0] S_EMIT_W = 4'd8;
    localparam logic [3:0] S_FAIL   = 4'd9;

    // Control state
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count;
    logic [SPW-1:0] r_sp, n_sp;
    logic [NV-1:0] r_visited, n_visited;

    // Working registers
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_start, n_start;
    logic [AW-1:0] r_end, n_end;
    logic [AW-1:0] r_v, n_v;

    // Memories and their registered read data
    logic [sgwp_pkg::ROW_W-1:0] r_adj_mem [NV];
    logic [NV-1:0]              r_adj_vld;
    logic [AW-1:0]              r_stack_mem [NV];
    logic [AW-1:0]              r_parent_mem [NV];
    logic [sgwp_pkg::ROW_W-1:0] r_adj_q;
    logic [AW-1:0]              r_stack_q;
    logic [AW-1:0]              r_parent_q;

    // Memory controls
    logic          adj_we, adj_re;
    logic          stk_we, stk_re;
    logic [AW-1:0] stk_wdata;
    logic          par_we, par_re;

    logic              in_acc;
    logic              in_range;
    logic              query_go;
    logic              row_ok;
    logic [CW-1:0]     eff_count;
    logic [CW-1:0]     lim;
    logic [SPW-1:0]    sp_m1;
    logic              pick_any;
    logic [AW-1:0]     pick_idx;
    logic              ld_out;
    logic              out_free;
    sgwp_pkg::t_result out_d;
    sgwp_pkg::t_result out_q;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Active vertex limit: count clamped to 1..NV.
    always_comb begin
        eff_count = (r_count == '0) ? CW'(1) : r_count;
        lim       = (eff_count > CW'(NV)) ? CW'(NV) : eff_count;
    end

    assign in_range = (CW'(i_start_vertex) < lim) && (CW'(i_end_vertex) < lim);
    assign query_go = in_acc && (i_action == sgwp_pkg::ACT_QUERY) && in_range;
    assign row_ok   = CW'(i_row_index) < CW'(NV);
    assign sp_m1    = r_sp - SPW'(1);

    sgwp_pick #(
        .NV (NV),
        .AW (AW)
    ) u_pick (
        .i_row     (r_adj_q[NV-1:0]),
        .i_visited (r_visited),
        .i_lim     (lim),
        .o_any     (pick_any),
        .o_idx     (pick_idx)
    );

    sgwp_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ld_out),
        .i_data  (out_d),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (out_q),
        .o_free  (out_free)
    );

    assign o_vertex = out_q.vertex;
    assign o_found  = out_q.found;
    assign o_last   = out_q.last;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_sp      = r_sp;
        n_visited = r_visited;
        n_cur     = r_cur;
        n_start   = r_start;
        n_end     = r_end;
        n_v       = r_v;
        adj_we    = 1'b0;
        adj_re    = 1'b0;
        stk_we    = 1'b0;
        stk_re    = 1'b0;
        stk_wdata = r_v;
        par_we    = 1'b0;
        par_re    = 1'b0;
        ld_out    = 1'b0;
        out_d     = '{vertex: '0, found: 1'b0, last: 1'b1};

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_action == sgwp_pkg::ACT_LOAD) begin
                        adj_we = row_ok;
                    end else if (!in_range) begin
                        n_state = S_FAIL;
                    end else begin
                        // Push the start with fresh visited marks.
                        n_start   = AW'(i_start_vertex);
                        n_end     = AW'(i_end_vertex);
                        n_visited = '0;
                        n_visited[AW'(i_start_vertex)] = 1'b1;
                        stk_we    = 1'b1;
                        stk_wdata = AW'(i_start_vertex);
                        n_sp      = SPW'(1);
                        n_state   = S_POP;
                    end
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_state = S_CHECK;
                end else begin
                    stk_re  = 1'b1;
                    n_sp    = sp_m1;
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                n_cur   = r_stack_q;
                adj_re  = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (pick_any) begin
                    stk_we    = 1'b1;
                    stk_wdata = pick_idx;
                    par_we    = 1'b1;
                    n_sp      = r_sp + SPW'(1);
                    n_visited[pick_idx] = 1'b1;
                end else begin
                    n_state = S_POP;
                end
            end
            S_CHECK: begin
                if (!r_visited[r_end]) begin
                    n_state = S_FAIL;
                end else begin
                    n_v     = r_end;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // Stack the path end first so the pops give it start first.
                stk_we    = 1'b1;
                stk_wdata = r_v;
                n_sp      = r_sp + SPW'(1);
                if (r_v == r_start) begin
                    n_state = S_EMIT;
                end else begin
                    par_re  = 1'b1;
                    n_state = S_WALK_W;
                end
            end
            S_WALK_W: begin
                n_v     = r_parent_q;
                n_state = S_WALK;
            end
            S_EMIT: begin
                if (out_free) begin
                    stk_re  = 1'b1;
                    n_sp    = sp_m1;
                    n_state = S_EMIT_W;
                end
            end
            S_EMIT_W: begin
                ld_out  = 1'b1;
                out_d   = '{vertex: sgwp_pkg::VERTEX_W'(r_stack_q), found: 1'b1,
                            last: (r_sp == '0)};
                n_state = (r_sp == '0) ? S_IDLE : S_EMIT;
            end
            S_FAIL: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sp      <= '0;
            r_visited <= '0;
            r_count   <= sgwp_pkg::COUNT_RESET;
        end else begin
            r_state   <= n_state;
            r_sp      <= n_sp;
            r_visited <= n_visited;
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_start <= n_start;
        r_end   <= n_end;
        r_v     <= n_v;
    end

    // Row valid bits: a row not loaded since reset reads as all zeros.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj_vld <= '0;
        end else if (adj_we) begin
            r_adj_vld[i_row_index[AW-1:0]] <= 1'b1;
        end
    end

    // Adjacency memory
    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            r_adj_mem[i_row_index[AW-1:0]] <= i_row_bits;
        end
        if (adj_re) begin
            r_adj_q <= r_adj_vld[r_stack_q] ? r_adj_mem[r_stack_q] : '0;
        end
    end

    // Vertex stack memory, also holds the path while it drains
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack_mem[r_sp[AW-1:0]] <= stk_wdata;
        end
        if (stk_re) begin
            r_stack_q <= r_stack_mem[sp_m1[AW-1:0]];
        end
    end

    // Parent memory
    always_ff @(posedge i_clk) begin
        if (par_we) begin
            r_parent_mem[pick_idx] <= r_cur;
        end
        if (par_re) begin
            r_parent_q <= r_parent_mem[r_v];
        end
    end

    `ASSERT_ALWAYS(a_sp_bound, r_sp <= SPW'(NV), "stack pointer beyond depth")
    `ASSERT_ALWAYS(a_out_free, !ld_out || out_free, "output loaded while occupied")
    `ASSERT_NEXT(a_start_mark, query_go, $onehot(r_visited), "visited marks not reset")

endmodule
